// ----- sv/indexed_max_heap_increment_key_core_assert.svh -----
// ----------------------------------------------------------------------------
// Indexed max-heap core assertion macros
// Property wrappers clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MAX_HEAP_INCREMENT_KEY_CORE_ASSERT_SVH
`define INDEXED_MAX_HEAP_INCREMENT_KEY_CORE_ASSERT_SVH

// same-cycle implication
`define IMHIK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imhik assertion failed");

// next-cycle implication
`define IMHIK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imhik assertion failed");

`endif

// ----- sv/imhik_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed max-heap core package
// Field widths, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package imhik_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 16;

    localparam int REQ_W    = 2;
    localparam int ELEM_W   = 10;
    localparam int OKEY_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INC     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INIT,
        S_X0, S_X1, S_X2, S_X3,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_D5,
        S_I0, S_I1,
        S_U0, S_U1, S_U2, S_U3,
        S_DONE
    } state_t;

endpackage

// ----- sv/imhik_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module imhik_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/indexed_max_heap_increment_key_core.sv -----
// ----------------------------------------------------------------------------
// Indexed max-heap core with increment-key
// Max-heap of element ids keyed by counters, with per-element position table.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per transfer (req_type, element).
//   0 init: places elements 0..n-1, keys zero, n = element_count (<= CAPACITY).
//   1 extract: returns root element and key, sifts the last entry down.
//   2 increment: adds one to the element's key (saturating), sifts it up.
// Result channel m_*: exactly one result transfer per request.
// Config channel cfg_*: writes element_count, used by the next init.
// Timing: sequential, one request at a time, state held in three RAMs with
//   registered reads. Init writes every slot, an empty extract or an unknown
//   request goes straight to the result, and extract and increment run one
//   sift loop pass per swap.
// Reset: a clearing pass over all CAPACITY elements marks them absent; no
//   request is accepted until it ends. Config writes are taken at any time.
// A finished result sits in the output register; the core waits for a
//   stalled receiver before loading the next one and then takes a new request.
// ----------------------------------------------------------------------------
module indexed_max_heap_increment_key_core #(
    parameter int CAPACITY = imhik_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = imhik_pkg::DEF_KEY_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [imhik_pkg::REQ_W-1:0]     s_req_type,
    input  logic [imhik_pkg::ELEM_W-1:0]    s_element,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [imhik_pkg::ELEM_W-1:0]    m_out_element,
    output logic [imhik_pkg::OKEY_W-1:0]    m_out_key,
    output logic [imhik_pkg::STATUS_W-1:0]  m_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [imhik_pkg::CNT_W-1:0]     cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = AW + 1;
    localparam int CW = SW + 1;
    localparam logic [AW-1:0]       LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [KEY_BITS-1:0] KEY_MAX  = {KEY_BITS{1'b1}};

    imhik_pkg::state_t state_reg, state_next;

    logic [imhik_pkg::CNT_W-1:0]    cnt_reg;
    logic [AW-1:0]                  idx_reg;
    logic [SW-1:0]                  n_reg;
    logic [SW-1:0]                  hs_reg;
    logic [imhik_pkg::ELEM_W-1:0]   elem_reg;
    logic [SW-1:0]                  s_reg;
    logic [SW-1:0]                  c_reg;
    logic [AW-1:0]                  x_reg;
    logic [KEY_BITS-1:0]            kx_reg;
    logic [AW-1:0]                  top_reg;
    logic [AW-1:0]                  elc_reg;
    logic [AW-1:0]                  elc1_reg;
    logic [KEY_BITS-1:0]            kc_reg;
    logic                           has_r_reg;
    logic [AW-1:0]                  pel_reg;
    logic [imhik_pkg::ELEM_W-1:0]   res_el_reg;
    logic [imhik_pkg::OKEY_W-1:0]   res_key_reg;
    logic [imhik_pkg::STATUS_W-1:0] res_st_reg;
    logic                           m_valid_reg;
    logic [imhik_pkg::ELEM_W-1:0]   m_el_reg;
    logic [imhik_pkg::OKEY_W-1:0]   m_key_reg;
    logic [imhik_pkg::STATUS_W-1:0] m_st_reg;

    // slot_element, element_slot, element_key
    logic                se_we, es_we, ek_we;
    logic [AW-1:0]       se_waddr, se_raddr, es_waddr, es_raddr, ek_waddr, ek_raddr;
    logic [AW-1:0]       se_wdata, se_rdata;
    logic [SW-1:0]       es_wdata, es_rdata;
    logic [KEY_BITS-1:0] ek_wdata, ek_rdata;

    imhik_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_slot_elem (
        .clk(aclk), .we(se_we), .waddr(se_waddr), .wdata(se_wdata),
        .raddr(se_raddr), .rdata(se_rdata)
    );

    imhik_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_elem_slot (
        .clk(aclk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
        .raddr(es_raddr), .rdata(es_rdata)
    );

    imhik_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_elem_key (
        .clk(aclk), .we(ek_we), .waddr(ek_waddr), .wdata(ek_wdata),
        .raddr(ek_raddr), .rdata(ek_rdata)
    );

    logic                s_fire;
    logic                out_load;
    logic                elem_in_range;
    logic [CW-1:0]       child;
    logic                pick_right;
    logic [KEY_BITS-1:0] best_key;
    logic [KEY_BITS-1:0] inc_key;
    logic [SW-1:0]       parent;

    assign s_ready       = (state_reg == imhik_pkg::S_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == imhik_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign elem_in_range = 32'(s_element) < 32'(CAPACITY);
    assign child         = {s_reg, 1'b0};
    assign pick_right    = has_r_reg && (ek_rdata > kc_reg);
    assign best_key      = pick_right ? ek_rdata : kc_reg;
    assign inc_key       = (ek_rdata == KEY_MAX) ? ek_rdata : ek_rdata + 1'b1;
    assign parent        = s_reg >> 1;

    assign m_valid       = m_valid_reg;
    assign m_out_element = m_el_reg;
    assign m_out_key     = m_key_reg;
    assign m_status      = m_st_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            imhik_pkg::S_CLEAR, imhik_pkg::S_INIT: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = (state_reg == imhik_pkg::S_INIT) ? imhik_pkg::S_DONE
                                                                 : imhik_pkg::S_IDLE;
                end
            end
            imhik_pkg::S_IDLE: begin
                if (s_fire) begin
                    unique case (s_req_type)
                        imhik_pkg::REQ_INIT:    state_next = imhik_pkg::S_INIT;
                        imhik_pkg::REQ_EXTRACT: state_next = (hs_reg == '0) ?
                                                    imhik_pkg::S_DONE : imhik_pkg::S_X0;
                        imhik_pkg::REQ_INC:     state_next = elem_in_range ?
                                                    imhik_pkg::S_I0 : imhik_pkg::S_DONE;
                        default:                state_next = imhik_pkg::S_DONE;
                    endcase
                end
            end
            imhik_pkg::S_X0: state_next = imhik_pkg::S_X1;
            imhik_pkg::S_X1: state_next = imhik_pkg::S_X2;
            imhik_pkg::S_X2: state_next = imhik_pkg::S_X3;
            imhik_pkg::S_X3: state_next = (hs_reg > SW'(1)) ? imhik_pkg::S_D0
                                                            : imhik_pkg::S_DONE;
            imhik_pkg::S_D0: state_next = (child > CW'(hs_reg)) ? imhik_pkg::S_DONE
                                                                : imhik_pkg::S_D1;
            imhik_pkg::S_D1: state_next = imhik_pkg::S_D2;
            imhik_pkg::S_D2: state_next = imhik_pkg::S_D3;
            imhik_pkg::S_D3: state_next = (kx_reg < best_key) ? imhik_pkg::S_D4
                                                              : imhik_pkg::S_DONE;
            imhik_pkg::S_D4: state_next = imhik_pkg::S_D5;
            imhik_pkg::S_D5: state_next = imhik_pkg::S_D0;
            imhik_pkg::S_I0: state_next = imhik_pkg::S_I1;
            imhik_pkg::S_I1: state_next = (es_rdata == '0) ? imhik_pkg::S_DONE
                                                           : imhik_pkg::S_U0;
            imhik_pkg::S_U0: state_next = (s_reg <= SW'(1)) ? imhik_pkg::S_DONE
                                                            : imhik_pkg::S_U1;
            imhik_pkg::S_U1: state_next = imhik_pkg::S_U2;
            imhik_pkg::S_U2: state_next = (ek_rdata < kx_reg) ? imhik_pkg::S_U3
                                                              : imhik_pkg::S_DONE;
            imhik_pkg::S_U3: state_next = imhik_pkg::S_U0;
            imhik_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = imhik_pkg::S_IDLE;
                end
            end
            default: state_next = imhik_pkg::S_CLEAR;
        endcase
    end

    // memory controls
    always_comb begin
        se_we = 1'b0; se_waddr = '0; se_wdata = '0; se_raddr = '0;
        es_we = 1'b0; es_waddr = '0; es_wdata = '0; es_raddr = '0;
        ek_we = 1'b0; ek_waddr = '0; ek_wdata = '0; ek_raddr = '0;
        unique case (state_reg)
            imhik_pkg::S_CLEAR, imhik_pkg::S_INIT: begin
                se_we = 1'b1; se_waddr = idx_reg; se_wdata = idx_reg;
                es_we = 1'b1; es_waddr = idx_reg;
                es_wdata = (SW'(idx_reg) < n_reg) ? SW'(idx_reg) + 1'b1 : '0;
                ek_we = 1'b1; ek_waddr = idx_reg; ek_wdata = '0;
            end
            imhik_pkg::S_X0: se_raddr = '0;
            imhik_pkg::S_X1: begin
                ek_raddr = se_rdata;
                se_raddr = AW'(hs_reg - 1'b1);
            end
            imhik_pkg::S_X2: begin
                ek_raddr = se_rdata;
                es_we = 1'b1; es_waddr = top_reg; es_wdata = '0;
            end
            imhik_pkg::S_X3: begin
                if (hs_reg > SW'(1)) begin
                    se_we = 1'b1; se_waddr = '0; se_wdata = x_reg;
                    es_we = 1'b1; es_waddr = x_reg; es_wdata = SW'(1);
                end
            end
            imhik_pkg::S_D0: se_raddr = AW'(child - 1'b1);
            imhik_pkg::S_D1: begin
                ek_raddr = se_rdata;
                se_raddr = AW'(c_reg);
            end
            imhik_pkg::S_D2: ek_raddr = se_rdata;
            imhik_pkg::S_D4: begin
                se_we = 1'b1; se_waddr = AW'(s_reg - 1'b1); se_wdata = elc_reg;
                es_we = 1'b1; es_waddr = elc_reg; es_wdata = s_reg;
            end
            imhik_pkg::S_D5: begin
                se_we = 1'b1; se_waddr = AW'(c_reg - 1'b1); se_wdata = x_reg;
                es_we = 1'b1; es_waddr = x_reg; es_wdata = c_reg;
            end
            imhik_pkg::S_I0: begin
                es_raddr = AW'(elem_reg);
                ek_raddr = AW'(elem_reg);
            end
            imhik_pkg::S_I1: begin
                if (es_rdata != '0) begin
                    ek_we = 1'b1; ek_waddr = x_reg; ek_wdata = inc_key;
                end
            end
            imhik_pkg::S_U0: se_raddr = AW'(parent - 1'b1);
            imhik_pkg::S_U1: ek_raddr = se_rdata;
            imhik_pkg::S_U2: begin
                if (ek_rdata < kx_reg) begin
                    se_we = 1'b1; se_waddr = AW'(parent - 1'b1); se_wdata = x_reg;
                    es_we = 1'b1; es_waddr = x_reg; es_wdata = parent;
                end
            end
            imhik_pkg::S_U3: begin
                se_we = 1'b1; se_waddr = AW'(s_reg - 1'b1); se_wdata = pel_reg;
                es_we = 1'b1; es_waddr = pel_reg; es_wdata = s_reg;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imhik_pkg::S_CLEAR;
            cnt_reg     <= imhik_pkg::CNT_RESET;
            idx_reg     <= '0;
            n_reg       <= '0;
            hs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cnt_reg <= cfg_data;
            end
            if (state_reg == imhik_pkg::S_CLEAR || state_reg == imhik_pkg::S_INIT) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX && state_reg == imhik_pkg::S_INIT) begin
                    hs_reg <= n_reg;
                end
            end
            if (s_fire && s_req_type == imhik_pkg::REQ_INIT) begin
                idx_reg <= '0;
                n_reg   <= (32'(cnt_reg) > 32'(CAPACITY)) ? SW'(CAPACITY) : SW'(cnt_reg);
            end
            if (state_reg == imhik_pkg::S_X3) begin
                hs_reg <= hs_reg - 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_el_reg  <= res_el_reg;
            m_key_reg <= res_key_reg;
            m_st_reg  <= res_st_reg;
        end
        case (state_reg)
            imhik_pkg::S_IDLE: begin
                elem_reg    <= s_element;
                res_el_reg  <= '0;
                res_key_reg <= '0;
                res_st_reg  <= imhik_pkg::STAT_OK;
                if (s_req_type == imhik_pkg::REQ_EXTRACT) begin
                    res_st_reg <= imhik_pkg::STAT_EMPTY;
                end else if (s_req_type == imhik_pkg::REQ_INC) begin
                    res_el_reg <= s_element;
                    res_st_reg <= imhik_pkg::STAT_ABSENT;
                end
            end
            imhik_pkg::S_X1: top_reg <= se_rdata;
            imhik_pkg::S_X2: begin
                res_el_reg  <= imhik_pkg::ELEM_W'(top_reg);
                res_key_reg <= imhik_pkg::OKEY_W'(ek_rdata);
                res_st_reg  <= imhik_pkg::STAT_OK;
                x_reg       <= se_rdata;
            end
            imhik_pkg::S_X3: begin
                kx_reg <= ek_rdata;
                s_reg  <= SW'(1);
            end
            imhik_pkg::S_D0: c_reg <= SW'(child);
            imhik_pkg::S_D1: begin
                elc_reg   <= se_rdata;
                has_r_reg <= c_reg < hs_reg;
            end
            imhik_pkg::S_D2: begin
                kc_reg   <= ek_rdata;
                elc1_reg <= se_rdata;
            end
            imhik_pkg::S_D3: begin
                if (pick_right) begin
                    c_reg   <= c_reg + 1'b1;
                    elc_reg <= elc1_reg;
                    kc_reg  <= ek_rdata;
                end
            end
            imhik_pkg::S_D5: s_reg <= c_reg;
            imhik_pkg::S_I0: x_reg <= AW'(elem_reg);
            imhik_pkg::S_I1: begin
                if (es_rdata != '0) begin
                    kx_reg      <= inc_key;
                    s_reg       <= es_rdata;
                    res_key_reg <= imhik_pkg::OKEY_W'(inc_key);
                    res_st_reg  <= imhik_pkg::STAT_OK;
                end
            end
            imhik_pkg::S_U1: pel_reg <= se_rdata;
            imhik_pkg::S_U3: s_reg <= parent;
            default: begin
            end
        endcase
    end

    `include "indexed_max_heap_increment_key_core_assert.svh"

    `IMHIK_ASSERT_IMP(a_size_bound, 1'b1, 32'(hs_reg) <= 32'(CAPACITY))
    `IMHIK_ASSERT_NXT(a_busy_after_req, s_fire, !s_ready)
    `IMHIK_ASSERT_NXT(a_result_loaded, out_load, m_valid && s_ready)

endmodule

// ----- dv/indexed_max_heap_increment_key_core_checker.sv -----
// ----------------------------------------------------------------------------
// Indexed max-heap result checker
// Watches the config, request and result channels at the rising edge, keeps
// its own copy of the heap, predicts one result per request transfer, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_max_heap_increment_key_core_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [imhik_pkg::REQ_W-1:0]        s_req_type,
    input  logic [imhik_pkg::ELEM_W-1:0]       s_element,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [imhik_pkg::ELEM_W-1:0]       m_out_element,
    input  logic [imhik_pkg::OKEY_W-1:0]       m_out_key,
    input  logic [imhik_pkg::STATUS_W-1:0]     m_status,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [imhik_pkg::CNT_W-1:0]        cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = imhik_pkg::DEF_CAPACITY;
    localparam logic [imhik_pkg::OKEY_W-1:0] KEY_SAT = '1;

    typedef struct packed {
        logic [imhik_pkg::ELEM_W-1:0]   elem;
        logic [imhik_pkg::OKEY_W-1:0]   key;
        logic [imhik_pkg::STATUS_W-1:0] stat;
    } heap_result_t;

    logic [imhik_pkg::ELEM_W-1:0] slot_elem [CAP];
    logic [imhik_pkg::CNT_W-1:0]  elem_slot [CAP];
    logic [imhik_pkg::OKEY_W-1:0] elem_key  [CAP];
    logic [imhik_pkg::CNT_W-1:0]  size_q;
    logic [imhik_pkg::CNT_W-1:0]  count_q;
    heap_result_t                 expected_results[$];

    function automatic logic [imhik_pkg::OKEY_W-1:0] key_of(int s);
        return elem_key[slot_elem[s-1]];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [imhik_pkg::ELEM_W-1:0] ea, eb;
        ea = slot_elem[a-1];
        eb = slot_elem[b-1];
        slot_elem[a-1] = eb;
        slot_elem[b-1] = ea;
        elem_slot[ea] = imhik_pkg::CNT_W'(b);
        elem_slot[eb] = imhik_pkg::CNT_W'(a);
    endfunction

    function automatic heap_result_t apply_request(logic [imhik_pkg::REQ_W-1:0] rq,
                                                   logic [imhik_pkg::ELEM_W-1:0] el);
        heap_result_t r;
        int n, s, c;
        logic [imhik_pkg::ELEM_W-1:0] top, last;
        r = '0;
        if (rq == imhik_pkg::REQ_INIT) begin
            n = (count_q > CAP) ? CAP : int'(count_q);
            for (int i = 0; i < CAP; i++) begin
                elem_key[i] = '0;
                elem_slot[i] = '0;
            end
            for (int i = 0; i < n; i++) begin
                slot_elem[i] = imhik_pkg::ELEM_W'(i);
                elem_slot[i] = imhik_pkg::CNT_W'(i + 1);
            end
            size_q = imhik_pkg::CNT_W'(n);
        end else if (rq == imhik_pkg::REQ_EXTRACT) begin
            if (size_q == 0) begin
                r.stat = imhik_pkg::STAT_EMPTY;
            end else begin
                top = slot_elem[0];
                r.elem = top;
                r.key = elem_key[top];
                if (size_q > 1) begin
                    last = slot_elem[size_q-1];
                    slot_elem[0] = last;
                    elem_slot[last] = imhik_pkg::CNT_W'(1);
                end
                elem_slot[top] = '0;
                size_q = size_q - 1'b1;
                s = 1;
                c = 2;
                while (c <= size_q) begin
                    if (c + 1 <= size_q && key_of(c + 1) > key_of(c))
                        c++;
                    if (key_of(s) < key_of(c))
                        swap_slots(s, c);
                    else
                        break;
                    s = c;
                    c = 2 * s;
                end
            end
        end else if (rq == imhik_pkg::REQ_INC) begin
            r.elem = el;
            if (elem_slot[el] == 0) begin
                r.stat = imhik_pkg::STAT_ABSENT;
            end else begin
                if (elem_key[el] != KEY_SAT)
                    elem_key[el] = elem_key[el] + 1'b1;
                r.key = elem_key[el];
                s = elem_slot[el];
                while (s > 1) begin
                    if (key_of(s / 2) < key_of(s))
                        swap_slots(s / 2, s);
                    else
                        break;
                    s = s / 2;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = expected_results.size();

    initial begin
        fail_count = 0;
        size_q = '0;
        count_q = imhik_pkg::CNT_RESET;
        for (int i = 0; i < CAP; i++) begin
            slot_elem[i] = '0;
            elem_slot[i] = '0;
            elem_key[i] = '0;
        end
    end

    always @(posedge aclk) begin
        heap_result_t e;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                count_q = cfg_data;
            if (s_valid && s_ready)
                expected_results.push_back(apply_request(s_req_type, s_element));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (m_out_element !== e.elem)
                        report_mismatch($sformatf("element got %0d exp %0d",
                                                  m_out_element, e.elem));
                    if (m_out_key !== e.key)
                        report_mismatch($sformatf("key got %0d exp %0d",
                                                  m_out_key, e.key));
                    if (m_status !== e.stat)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  m_status, e.stat));
                end
            end
        end
    end
endmodule

// ----- dv/indexed_max_heap_increment_key_core_tb.sv -----
// ----------------------------------------------------------------------------
// Indexed max-heap testbench
// Drives init, extract, increment and reserved requests plus element_count writes,
// with random sender gaps and receiver stalls; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module indexed_max_heap_increment_key_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [imhik_pkg::REQ_W-1:0]    s_req_type = imhik_pkg::REQ_INIT;
    logic [imhik_pkg::ELEM_W-1:0]   s_element = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [imhik_pkg::ELEM_W-1:0]   m_out_element;
    logic [imhik_pkg::OKEY_W-1:0]   m_out_key;
    logic [imhik_pkg::STATUS_W-1:0] m_status;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [imhik_pkg::CNT_W-1:0]    cfg_data = '0;
    int                             fail_count;
    int                             pending;
    int                             send_idle_pct = 0;
    int                             stall_pct = 0;
    bit                             hold_req = 1'b0;
    bit                             hold_taken = 1'b0;
    int                             hold_off = 0;
    int                             cycle_count = 0;
    int                             live_count = 1024;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    indexed_max_heap_increment_key_core dut (.*);

    indexed_max_heap_increment_key_core_checker chk (.*);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_off = 300;
        end
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays up after the transfer until the next call or an explicit drop
    task automatic send_request(logic [imhik_pkg::REQ_W-1:0] rq,
                                logic [imhik_pkg::ELEM_W-1:0] el);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rq;
        s_element <= el;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_count(logic [imhik_pkg::CNT_W-1:0] n);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        live_count = (n > 1024) ? 1024 : int'(n);
    endtask

    task automatic random_request();
        int p;
        p = $urandom_range(99);
        if (p < 3)
            send_request(imhik_pkg::REQ_INIT, imhik_pkg::ELEM_W'($urandom));
        else if (p < 25)
            send_request(imhik_pkg::REQ_EXTRACT, imhik_pkg::ELEM_W'($urandom));
        else if (p < 30)
            send_request(imhik_pkg::REQ_RSVD, imhik_pkg::ELEM_W'($urandom));
        else if (p < 37)
            send_request(imhik_pkg::REQ_INC, imhik_pkg::ELEM_W'($urandom));
        else
            send_request(imhik_pkg::REQ_INC,
                         imhik_pkg::ELEM_W'($urandom_range(live_count + 1)));
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // before any init
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        send_request(imhik_pkg::REQ_INC, 10'd5);
        send_request(imhik_pkg::REQ_RSVD, 10'h3FF);
        // full capacity at reset value
        send_request(imhik_pkg::REQ_INIT, '0);
        send_request(imhik_pkg::REQ_INC, 10'h3FF);
        send_request(imhik_pkg::REQ_INC, 10'h3FF);
        send_request(imhik_pkg::REQ_INC, 10'd0);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        send_request(imhik_pkg::REQ_INC, 10'h3FF);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        // tiny heap, empty heap, oversized count
        write_count(11'd2);
        send_request(imhik_pkg::REQ_INIT, '0);
        send_request(imhik_pkg::REQ_INC, 10'd1);
        send_request(imhik_pkg::REQ_INC, 10'd2);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        send_request(imhik_pkg::REQ_INC, 10'd0);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        write_count(11'd0);
        send_request(imhik_pkg::REQ_INIT, '0);
        send_request(imhik_pkg::REQ_EXTRACT, '0);
        write_count(11'h7FF);
        send_request(imhik_pkg::REQ_INIT, '0);
        send_request(imhik_pkg::REQ_EXTRACT, '0);

        // random phases over several element counts
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            write_count(ph == 3 ? 11'd1 : imhik_pkg::CNT_W'($urandom_range(3, 40)));
            send_request(imhik_pkg::REQ_INIT, '0);
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < 95; i++)
                random_request();
        end

        // long key chain on one element; saturation is out of reach here
        send_idle_pct = 0;
        stall_pct = 0;
        write_count(11'd1);
        send_request(imhik_pkg::REQ_INIT, '0);
        repeat (20) send_request(imhik_pkg::REQ_INC, '0);

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
